@@ src/bprsh_pkg.sv @@
// Shared types and constants for the bit-packed record to sparse hit converter.
package bprsh_pkg;

	localparam int MAX_RECORD_BITS = 65568;
	localparam int MAX_OBSERVABLES = 32;

	// Widths of the configuration fields and the record state
	localparam int MB_W   = 17;
	localparam int OBS_W  = 6;
	localparam int BP_W   = 14;
	localparam int BASE_W = 13;
	localparam int MASK_W = 32;
	localparam int IDX_W  = 16;

	// Largest usable main_bits value
	localparam logic [MB_W-1:0] MAIN_CAP = MB_W'(MAX_RECORD_BITS - MAX_OBSERVABLES);

	// Register reset values
	localparam logic [MB_W-1:0]  MB_RST  = 17'd8;
	localparam logic [OBS_W-1:0] OBS_RST = 6'd0;

	// Queue between classifier and serializer
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// Register map (index taken from paddr[2])
	localparam logic REG_MAIN_BITS = 1'b0;
	localparam logic REG_OBS_COUNT = 1'b1;

	typedef enum logic [2:0] {
		KIND_HIT        = 3'd0,
		KIND_REC_END    = 3'd1,
		KIND_STREAM_END = 3'd2,
		KIND_TRUNC      = 3'd3,
		KIND_TOO_LARGE  = 3'd4
	} kind_t;

	// Derived configuration seen by the classifier
	typedef struct packed {
		logic [MB_W-1:0] mb_eff;
		logic [MB_W-1:0] n_bits;
		logic [BP_W-1:0] last_byte;
		logic            obs_over;
		logic            clr;
	} cfg_t;

	// One queued item: its hits, and an optional closing result
	typedef struct packed {
		logic [7:0]        hits;
		logic [BASE_W-1:0] base;
		logic              has_end;
		kind_t             end_kind;
		logic [MASK_W-1:0] mask;
	} ent_t;

endpackage

@@ src/bprsh_cfg.sv @@
// Configuration registers with APB-style access and derived record geometry.
module bprsh_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output bprsh_pkg::cfg_t        cfg
);

	logic                         wr;
	logic [bprsh_pkg::MB_W-1:0]   mb_raw_q;
	logic [bprsh_pkg::OBS_W-1:0]  obs_q;
	logic [bprsh_pkg::MB_W-1:0]   mb_eff_q;
	logic [bprsh_pkg::MB_W-1:0]   n_bits_q;
	logic [bprsh_pkg::BP_W-1:0]   last_byte_q;
	logic                         obs_over_q;
	logic [bprsh_pkg::MB_W-1:0]   mb_nx;
	logic [bprsh_pkg::OBS_W-1:0]  obs_nx;
	logic [bprsh_pkg::MB_W-1:0]   eff_nx;
	logic [bprsh_pkg::MB_W-1:0]   n_nx;
	logic [bprsh_pkg::BP_W-1:0]   nb_nx;
	logic [bprsh_pkg::BP_W-1:0]   last_nx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	// Compute next register values and record geometry
	always_comb begin
		mb_nx  = mb_raw_q;
		obs_nx = obs_q;
		if (wr && paddr[2] == bprsh_pkg::REG_MAIN_BITS) begin
			mb_nx = pwdata[bprsh_pkg::MB_W-1:0];
		end
		if (wr && paddr[2] == bprsh_pkg::REG_OBS_COUNT) begin
			obs_nx = pwdata[bprsh_pkg::OBS_W-1:0];
		end
		eff_nx  = (mb_nx > bprsh_pkg::MAIN_CAP) ? bprsh_pkg::MAIN_CAP : mb_nx;
		n_nx    = eff_nx + bprsh_pkg::MB_W'(obs_nx);
		nb_nx   = bprsh_pkg::BP_W'((n_nx + bprsh_pkg::MB_W'(7)) >> 3);
		last_nx = (nb_nx == '0) ? '0 : nb_nx - bprsh_pkg::BP_W'(1);
	end

	// Hold registers, update on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mb_raw_q    <= bprsh_pkg::MB_RST;
			obs_q       <= bprsh_pkg::OBS_RST;
			mb_eff_q    <= bprsh_pkg::MB_RST;
			n_bits_q    <= bprsh_pkg::MB_RST;
			last_byte_q <= '0;
			obs_over_q  <= 1'b0;
		end else if (wr) begin
			mb_raw_q    <= mb_nx;
			obs_q       <= obs_nx;
			mb_eff_q    <= eff_nx;
			n_bits_q    <= n_nx;
			last_byte_q <= last_nx;
			obs_over_q  <= (obs_nx > bprsh_pkg::OBS_W'(bprsh_pkg::MAX_OBSERVABLES));
		end
	end

	// Return register contents on read
	always_comb begin
		case (paddr[2])
			bprsh_pkg::REG_MAIN_BITS: prdata = 32'(mb_raw_q);
			bprsh_pkg::REG_OBS_COUNT: prdata = 32'(obs_q);
			default:                  prdata = '0;
		endcase
	end

	assign cfg.mb_eff    = mb_eff_q;
	assign cfg.n_bits    = n_bits_q;
	assign cfg.last_byte = last_byte_q;
	assign cfg.obs_over  = obs_over_q;
	assign cfg.clr       = wr;

endmodule

@@ src/bprsh_front.sv @@
// Classifier: accepts bytes, sorts their bits into hits, observables and padding.
module bprsh_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bprsh_pkg::cfg_t              cfg,
	input  logic                         in_valid,
	input  logic                         q_full,
	input  logic [7:0]                   data_byte,
	input  logic                         end_of_data,
	output logic                         in_ready,
	output logic                         push,
	output bprsh_pkg::ent_t              ent
);

	logic [bprsh_pkg::BP_W-1:0]   bp_q;
	logic [bprsh_pkg::MASK_W-1:0] acc_q;
	logic                         accept;
	logic [bprsh_pkg::MB_W-1:0]   base;
	logic signed [bprsh_pkg::MB_W:0] dmb;
	logic signed [bprsh_pkg::MB_W:0] dn;
	logic [7:0]                   hit_v;
	logic [7:0]                   bad_v;
	logic [bprsh_pkg::MASK_W-1:0] acc_new;
	logic                         rec_end;
	logic                         bad;
	logic                         done;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign base     = {bp_q[bprsh_pkg::MB_W-4:0], 3'b000};
	assign dmb      = $signed({1'b0, cfg.mb_eff}) - $signed({1'b0, base});
	assign dn       = $signed({1'b0, cfg.n_bits}) - $signed({1'b0, base});
	assign rec_end  = (bp_q >= cfg.last_byte);

	// Classify each bit of the byte against the record layout
	always_comb begin
		logic [6:0] off;
		acc_new = acc_q;
		hit_v   = '0;
		bad_v   = '0;
		for (int r = 0; r < 8; r++) begin
			off = 7'(7'(r) - dmb[6:0]);
			if (data_byte[r]) begin
				if (dmb > $signed((bprsh_pkg::MB_W+1)'(r))) begin
					hit_v[r] = 1'b1;
				end else if (dn > $signed((bprsh_pkg::MB_W+1)'(r))) begin
					if (off[6:5] == 2'b00) begin
						acc_new[off[4:0]] = 1'b1;
					end
				end else begin
					bad_v[r] = 1'b1;
				end
			end
		end
	end

	assign bad = (|bad_v) || cfg.obs_over;

	// Build the queue entry
	always_comb begin
		ent.base = bp_q[bprsh_pkg::BASE_W-1:0];
		if (end_of_data) begin
			ent.hits     = '0;
			ent.has_end  = 1'b1;
			ent.end_kind = (bp_q == '0) ? bprsh_pkg::KIND_STREAM_END : bprsh_pkg::KIND_TRUNC;
			ent.mask     = '0;
		end else begin
			ent.hits     = hit_v;
			ent.has_end  = rec_end;
			ent.end_kind = bad ? bprsh_pkg::KIND_TOO_LARGE : bprsh_pkg::KIND_REC_END;
			ent.mask     = bad ? '0 : acc_new;
		end
	end

	assign done = end_of_data || rec_end;
	assign push = accept && (end_of_data || (|hit_v) || rec_end);

	// Advance the byte position, restart at record end, stream end or config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q  <= '0;
			acc_q <= '0;
		end else if (cfg.clr) begin
			bp_q  <= '0;
			acc_q <= '0;
		end else if (accept) begin
			if (done) begin
				bp_q  <= '0;
				acc_q <= '0;
			end else begin
				bp_q  <= bp_q + bprsh_pkg::BP_W'(1);
				acc_q <= acc_new;
			end
		end
	end

	// A record never runs past its last byte
	a_bp_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		bp_q <= cfg.last_byte || $past(cfg.clr))
		else $error("byte position beyond record length");

endmodule

@@ src/bprsh_queue.sv @@
// Short queue of classified items between classifier and serializer.
module bprsh_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bprsh_pkg::ent_t     wdata,
	input  logic                pop,
	output bprsh_pkg::ent_t     rdata,
	output logic                empty,
	output logic                full
);

	bprsh_pkg::ent_t            mem_q [bprsh_pkg::QDEPTH];
	logic [bprsh_pkg::QAW-1:0]  wp_q;
	logic [bprsh_pkg::QAW-1:0]  rp_q;
	logic [bprsh_pkg::QAW:0]    cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (bprsh_pkg::QAW+1)'(bprsh_pkg::QDEPTH));
	assign rdata = mem_q[rp_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + bprsh_pkg::QAW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + bprsh_pkg::QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (bprsh_pkg::QAW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (bprsh_pkg::QAW+1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

@@ src/bprsh_back.sv @@
// Serializer: turns one queued item into its hit and closing results.
module bprsh_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bprsh_pkg::ent_t               q_data,
	input  logic                          q_empty,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    kind,
	output logic [bprsh_pkg::IDX_W-1:0]   hit_index,
	output logic [bprsh_pkg::MASK_W-1:0]  obs_bits,
	output logic                          last
);

	bprsh_pkg::ent_t  cur_q;
	logic             cur_valid_q;
	logic [7:0]       lo;
	logic [7:0]       rest;
	logic [2:0]       lo_idx;
	logic             has_hit;
	logic             final_res;
	logic             taken;

	assign has_hit   = (cur_q.hits != '0);
	assign lo        = cur_q.hits & (~cur_q.hits + 8'd1);
	assign rest      = cur_q.hits & ~lo;
	assign final_res = !has_hit || (rest == '0 && !cur_q.has_end);

	// Encode the lowest pending hit bit
	always_comb begin
		lo_idx = '0;
		for (int r = 0; r < 8; r++) begin
			if (lo[r]) begin
				lo_idx = 3'(r);
			end
		end
	end

	// Present the current result
	assign out_valid = cur_valid_q;
	assign kind      = has_hit ? bprsh_pkg::KIND_HIT : cur_q.end_kind;
	assign hit_index = has_hit ? {cur_q.base, lo_idx} : '0;
	assign obs_bits  = has_hit ? '0 : cur_q.mask;
	assign last      = final_res;

	assign taken = cur_valid_q && out_ready;
	assign pop   = !q_empty && (!cur_valid_q || (taken && final_res));

	// Load the next item or drop the delivered hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
		end else if (taken && final_res) begin
			cur_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end else if (taken && !final_res) begin
			cur_q.hits <= rest;
		end
	end

	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> has_hit || cur_q.has_end)
		else $error("serializer holds an item with no results");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		taken && !final_res |=> cur_valid_q)
		else $error("item dropped before its last result");

endmodule

@@ src/bit_packed_record_to_sparse_hits.sv @@
// Top level of the bit-packed record to sparse hit converter.
//
// Input channel (in_valid/in_ready): one item per cycle, carrying data_byte
// or, with end_of_data set, the end-of-stream marker. Record bits are taken
// LSB first; each record holds main_bits + obs_count bits padded to bytes.
// Output channel (out_valid/out_ready): one result per cycle: a hit per set
// main bit in ascending order, then a record end with the observable mask,
// or stream end, truncated record or index-too-large; last marks the final
// result of an item. Items with no result (a middle byte with no hits) emit
// nothing.
// Throughput: one item per cycle while the four-entry queue has room; the
// serializer sends one result per cycle while out_ready is high, so a byte
// with k results holds it until all k are taken. An accepted item is first
// written to the queue, then loaded into the register that drives out_valid.
// A stalled receiver fills the queue, after which in_ready drops.
// Reset returns main_bits to 8, obs_count to 0 and the block to record start.
// Any register write over the APB port also returns it to record start.
module bit_packed_record_to_sparse_hits (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    kind,
	output logic [bprsh_pkg::IDX_W-1:0]   hit_index,
	output logic [bprsh_pkg::MASK_W-1:0]  obs_bits,
	output logic                          last
);

	bprsh_pkg::cfg_t  cfg;
	bprsh_pkg::ent_t  push_ent;
	bprsh_pkg::ent_t  head_ent;
	logic             push;
	logic             pop;
	logic             q_empty;
	logic             q_full;

	bprsh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bprsh_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.q_full      (q_full),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.in_ready    (in_ready),
		.push        (push),
		.ent         (push_ent)
	);

	bprsh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_ent),
		.pop    (pop),
		.rdata  (head_ent),
		.empty  (q_empty),
		.full   (q_full)
	);

	bprsh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (head_ent),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.hit_index (hit_index),
		.obs_bits  (obs_bits),
		.last      (last)
	);

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the bit-packed record to sparse hit converter.
`timescale 1ns / 100ps

module testbench;

	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int PRINT_LIMIT  = 100;

	// One expected result of the converter
	typedef struct {
		bprsh_pkg::kind_t kind;
		logic [15:0]      idx;
		logic [31:0]      mask;
		logic             last;
	} hit_rec_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        end_of_data;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [bprsh_pkg::IDX_W-1:0]  hit_index;
	logic [bprsh_pkg::MASK_W-1:0] obs_bits;
	logic        last;

	// Predictor state and configuration copy
	logic [bprsh_pkg::MB_W-1:0]  cfg_main_bits;
	logic [bprsh_pkg::OBS_W-1:0] cfg_obs_count;
	int               rec_byte_pos;
	logic [31:0]      obs_accum;
	hit_rec_t         expected_hits[$];

	int err_count;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_req;
	int stall_left;

	bit_packed_record_to_sparse_hits dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .end_of_data(end_of_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .hit_index(hit_index), .obs_bits(obs_bits), .last(last)
	);

	// Clock: 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: random idling, plus a long hold-off on request
	always @(posedge clk) begin
		if (stall_req > 0) begin
			stall_left = stall_req;
			stall_req = 0;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic report_error(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_count < PRINT_LIMIT)
			$display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
		err_count++;
	endtask

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		hit_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				report_error("unexpected result, kind", 32'(kind), 32'd0);
			end else begin
				want = expected_hits.pop_front();
				if (kind !== want.kind)
					report_error("kind", 32'(kind), 32'(want.kind));
				if (hit_index !== want.idx)
					report_error("hit_index", 32'(hit_index), 32'(want.idx));
				if (obs_bits !== want.mask)
					report_error("obs_bits", obs_bits, want.mask);
				if (last !== want.last)
					report_error("last", 32'(last), 32'(want.last));
			end
		end
	end

	// Append one result to the expected list
	function automatic void queue_result(input hit_rec_t r);
		expected_hits.insert(expected_hits.size(), r);
	endfunction

	function automatic int main_eff();
		return (cfg_main_bits > bprsh_pkg::MAIN_CAP) ? int'(bprsh_pkg::MAIN_CAP)
			: int'(cfg_main_bits);
	endfunction

	function automatic int record_bits();
		return main_eff() + int'(cfg_obs_count);
	endfunction

	function automatic int record_bytes();
		int nb;
		nb = (record_bits() + 7) >> 3;
		if (nb == 0)
			nb = 1;
		return nb;
	endfunction

	// Work out the results one accepted item causes
	function automatic void decode_item(input logic [7:0] b, input logic eod);
		hit_rec_t found[9];
		int mb, n, nb, idx, bit_n, cnt;
		logic bad;
		mb = main_eff();
		n = record_bits();
		nb = record_bytes();
		cnt = 0;
		bad = 1'b0;
		if (eod) begin
			found[0] = '{kind: (rec_byte_pos == 0) ? bprsh_pkg::KIND_STREAM_END
					: bprsh_pkg::KIND_TRUNC,
				idx: 16'd0, mask: 32'd0, last: 1'b1};
			queue_result(found[0]);
			rec_byte_pos = 0;
			obs_accum = 32'd0;
			return;
		end
		for (bit_n = 0; bit_n < 8; bit_n++) begin
			if (!b[bit_n])
				continue;
			idx = rec_byte_pos * 8 + bit_n;
			if (idx < mb) begin
				found[cnt] = '{kind: bprsh_pkg::KIND_HIT, idx: 16'(idx), mask: 32'd0,
					last: 1'b0};
				cnt++;
			end else if (idx < n) begin
				if (idx - mb < bprsh_pkg::MAX_OBSERVABLES)
					obs_accum[idx - mb] = 1'b1;
			end else begin
				bad = 1'b1;
			end
		end
		// Close the record on its last byte
		if (rec_byte_pos + 1 >= nb) begin
			if (cfg_obs_count > bprsh_pkg::MAX_OBSERVABLES)
				bad = 1'b1;
			if (bad)
				found[cnt] = '{kind: bprsh_pkg::KIND_TOO_LARGE, idx: 16'd0, mask: 32'd0,
					last: 1'b0};
			else
				found[cnt] = '{kind: bprsh_pkg::KIND_REC_END, idx: 16'd0, mask: obs_accum,
					last: 1'b0};
			cnt++;
			rec_byte_pos = 0;
			obs_accum = 32'd0;
		end else begin
			rec_byte_pos++;
		end
		if (cnt > 0)
			found[cnt - 1].last = 1'b1;
		for (idx = 0; idx < cnt; idx++)
			queue_result(found[idx]);
	endfunction

	// Offer one item, hold it until accepted
	task automatic send_item(input logic [7:0] value, input logic eod);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		end_of_data <= eod;
		do @(posedge clk); while (!in_ready);
		decode_item(value, eod);
	endtask

	// Stop sending and wait for every expected result
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic write_reg(input logic reg_sel, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (reg_sel == bprsh_pkg::REG_MAIN_BITS)
			cfg_main_bits = value[bprsh_pkg::MB_W-1:0];
		else
			cfg_obs_count = value[bprsh_pkg::OBS_W-1:0];
		rec_byte_pos = 0;
		obs_accum = 32'd0;
		@(posedge clk);
	endtask

	task automatic set_format(input logic [31:0] mb, input logic [31:0] oc);
		drain();
		write_reg(bprsh_pkg::REG_MAIN_BITS, mb);
		write_reg(bprsh_pkg::REG_OBS_COUNT, oc);
	endtask

	// Reset values: eight hit bits, no observables
	task automatic test_reset_defaults();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h81, 1'b0);
		send_item(8'h5A, 1'b1);
		send_item(8'hA5, 1'b1);
		drain();
	endtask

	// Observable bits gathered into the mask, up to the full 32
	task automatic test_observable_mask();
		set_format(32'd5, 32'd3);
		send_item(8'hFF, 1'b0);
		send_item(8'hE0, 1'b0);
		send_item(8'h1F, 1'b0);
		set_format(32'd4, 32'd32);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h0F, 1'b0);
		drain();
	endtask

	// Set padding bits end the record with index too large
	task automatic test_padding_bits();
		set_format(32'd5, 32'd2);
		send_item(8'h80, 1'b0);
		send_item(8'h9F, 1'b0);
		send_item(8'h60, 1'b0);
		drain();
	endtask

	// Zero-length record: one byte of padding only
	task automatic test_empty_record();
		set_format(32'd0, 32'd0);
		send_item(8'h00, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h00, 1'b1);
		drain();
	endtask

	// More observables than supported: every record ends too large
	task automatic test_excess_observables();
		int i;
		set_format(32'd8, 32'd63);
		for (i = 0; i < 9; i++)
			send_item(i == 0 ? 8'h03 : 8'h00, 1'b0);
		set_format(32'd0, 32'd33);
		for (i = 0; i < 5; i++)
			send_item(8'h01, 1'b0);
		drain();
	endtask

	// End of data inside a record, at a boundary, and a restart after it
	task automatic test_truncation();
		set_format(32'd20, 32'd4);
		send_item(8'h10, 1'b0);
		send_item(8'hC3, 1'b1);
		send_item(8'h00, 1'b1);
		send_item(8'h02, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hF8, 1'b0);
		drain();
	endtask

	// A register write in the middle of a record restarts it
	task automatic test_config_restart();
		set_format(32'd16, 32'd0);
		send_item(8'h01, 1'b0);
		drain();
		write_reg(bprsh_pkg::REG_MAIN_BITS, 32'd16);
		send_item(8'h02, 1'b0);
		send_item(8'h80, 1'b0);
		drain();
	endtask

	// Saturated main_bits, then main_bits at the cap; records cut short
	task automatic test_largest_record();
		set_format(32'hFFFF_FFFF, 32'd32);
		send_item(8'h01, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		set_format(32'd65536, 32'd0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		drain();
	endtask

	// Hold off the receiver long enough to fill the block, then pause the sender
	task automatic test_input_stall();
		int i;
		set_format(32'd8, 32'd0);
		stall_req = 400;
		for (i = 0; i < 30; i++)
			send_item(($urandom_range(3) == 0) ? 8'($urandom) : 8'hFF, 1'b0);
		drain();
		for (i = 0; i < 10; i++)
			send_item(8'hFF, 1'b0);
		drain();
	endtask

	// Random format, with garbage in unused register bits at times
	task automatic pick_random_config();
		logic [31:0] mb, oc;
		case ($urandom_range(9))
			0: mb = 32'd0;
			1: mb = $urandom_range(41, 300);
			default: mb = $urandom_range(1, 40);
		endcase
		case ($urandom_range(9))
			0: oc = $urandom_range(33, 63);
			1: oc = 32'd32;
			2: oc = 32'd0;
			default: oc = $urandom_range(1, 31);
		endcase
		if ($urandom_range(9) == 0)
			mb = mb | ($urandom & 32'hFFFE_0000);
		if ($urandom_range(9) == 0)
			oc = oc | ($urandom & 32'hFFFF_FFC0);
		set_format(mb, oc);
	endtask

	// Mostly whole records with random content; some early ends and noise
	task automatic send_random_records(input int item_budget, output int sent);
		int nb, n, i, tail_bits;
		logic [7:0] b;
		sent = 0;
		while (sent < item_budget) begin
			nb = record_bytes();
			n = record_bits();
			if ($urandom_range(99) < 8) begin
				send_item(8'($urandom), 1'b1);
				sent++;
			end else begin
				for (i = 0; i < nb; i++) begin
					b = 8'($urandom);
					if ($urandom_range(1) == 1)
						b = b & 8'($urandom) & 8'($urandom);
					if (i == nb - 1 && $urandom_range(99) < 75) begin
						tail_bits = n - 8 * (nb - 1);
						if (tail_bits < 8)
							b = b & 8'((1 << tail_bits) - 1);
					end
					if (i > 0 && $urandom_range(99) < 4) begin
						send_item(b, 1'b1);
						sent++;
						break;
					end
					send_item(b, 1'b0);
					sent++;
				end
			end
		end
	endtask

	// Three idling phases of random records
	task automatic test_random_records();
		int phase, total, sent;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 21;
					recv_idle_pct = 52;
				end
				1: begin
					send_idle_pct = 52;
					recv_idle_pct = 21;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			total = 0;
			while (total < 110) begin
				pick_random_config();
				send_random_records($urandom_range(20, 45), sent);
				total += sent;
			end
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		end_of_data <= 1'b0;
		out_ready <= 1'b0;
		cycle_count <= 0;
		err_count = 0;
		stall_req = 0;
		stall_left = 0;
		send_idle_pct = 21;
		recv_idle_pct = 52;
		cfg_main_bits = bprsh_pkg::MB_RST;
		cfg_obs_count = bprsh_pkg::OBS_RST;
		rec_byte_pos = 0;
		obs_accum = 32'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_observable_mask();
		test_padding_bits();
		test_empty_record();
		test_excess_observables();
		test_truncation();
		test_config_restart();
		test_largest_record();
		test_input_stall();
		test_random_records();

		drain();
		if (expected_hits.size() != 0)
			report_error("results never received", expected_hits.size(), 32'd0);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
